### rtl/bci_pkg.sv
package bci_pkg;

    // Number of data octets in one full block before a CRC pair is inserted.
    localparam int BLOCK_BYTES = 16;

    // Width of the block octet counter; it holds values up to BLOCK_BYTES.
    localparam int CNT_W = $clog2(BLOCK_BYTES + 1);

    // Reflected form of the CRC-16 polynomial 0x3D65.
    localparam logic [15:0] CRC_REV_POLY = 16'hA6BC;

    // Output sequencer: which CRC octet, if any, still waits to be sent.
    typedef enum logic [2:0] {
        PEND_NONE = 3'b001,
        PEND_LOW  = 3'b010,
        PEND_HIGH = 3'b100
    } pend_state_t;

    // Folds one octet into the running CRC, least significant bit first.
    function automatic logic [15:0] crc_add_octet(input logic [15:0] crc,
                                                  input logic [7:0]  octet);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ octet[i];
            c  = {1'b0, c[15:1]};
            if (fb) begin
                c = c ^ CRC_REV_POLY;
            end
        end
        return c;
    endfunction

endpackage

### rtl/block_crc16_inserter_top.sv
// Block CRC-16 inserter for link-layer user data.
//
// The input channel (in_valid, in_ready, data_byte, end_of_message) takes one
// user data octet per item. The output channel (out_valid, out_ready, out_byte,
// is_crc, last_out) passes every data octet through and, after every 16th octet
// of a block or after the octet that ends the message, appends the inverted
// CRC-16 of the block, low octet first. last_out marks the CRC high octet that
// closes the message.
//
// An input item is held in an input register and then moved into the output
// register, so a data octet passes through both registers before the receiver
// can take it. Items that only pass through flow at one per cycle while out_ready
// stays high and no CRC octets wait. An item that closes a block occupies the
// output register for its data octet, then the CRC low and CRC high octets; the
// sustained rate is set by that output register, which sends one octet per cycle
// while the receiver keeps out_ready high.
//
// Reset clears the CRC accumulator, the block count and all valid flags. When
// the receiver holds out_ready low, the output octet stays put, the input
// register fills and then in_ready falls until the output moves again.
module block_crc16_inserter_top
    import bci_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       end_of_message,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       is_crc,
    output logic       last_out
);

    // Input register.
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_eom_reg;

    // Running block state.
    logic [15:0]      crc_reg;
    logic [15:0]      crc_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Output register and the CRC octets that still wait behind it.
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_crc_reg;
    logic             out_last_reg;
    pend_state_t      pend_reg;
    pend_state_t      pend_next;
    logic [15:0]      pend_crc_reg;
    logic             pend_last_reg;

    logic             slot_free;
    logic             in_take;
    logic [15:0]      crc_upd;
    logic [CNT_W-1:0] count_inc;
    logic             close_block;

    // The output register can be loaded when it is empty or is being emptied.
    assign slot_free = !out_valid_reg || out_ready;

    // A data octet moves on only when no CRC octet is still queued.
    assign in_take  = slot_free && in_valid_reg && (pend_reg == PEND_NONE);
    assign in_ready = !in_valid_reg || in_take;

    assign crc_upd     = crc_add_octet(crc_reg, in_byte_reg);
    assign count_inc   = count_reg + 1'b1;
    assign close_block = in_eom_reg || (count_inc >= CNT_W'(BLOCK_BYTES));

    always_comb
    begin
        crc_next   = crc_reg;
        count_next = count_reg;
        if (in_take) begin
            crc_next   = close_block ? 16'h0000 : crc_upd;
            count_next = close_block ? '0 : count_inc;
        end
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (slot_free) begin
            case (pend_reg)
                PEND_LOW:  pend_next = PEND_HIGH;
                PEND_HIGH: pend_next = PEND_NONE;
                PEND_NONE: pend_next = (in_take && close_block) ? PEND_LOW : PEND_NONE;
                default:   pend_next = PEND_NONE;
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pend_reg      <= PEND_NONE;
            crc_reg       <= 16'h0000;
            count_reg     <= '0;
        end else begin
            if (in_ready) begin
                in_valid_reg <= in_valid;
            end
            if (slot_free) begin
                out_valid_reg <= (pend_reg != PEND_NONE) || in_take;
            end
            pend_reg  <= pend_next;
            crc_reg   <= crc_next;
            count_reg <= count_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            in_byte_reg <= data_byte;
            in_eom_reg  <= end_of_message;
        end
        if (slot_free) begin
            if (pend_reg == PEND_LOW) begin
                out_byte_reg <= pend_crc_reg[7:0];
                out_crc_reg  <= 1'b1;
                out_last_reg <= 1'b0;
            end else if (pend_reg == PEND_HIGH) begin
                out_byte_reg <= pend_crc_reg[15:8];
                out_crc_reg  <= 1'b1;
                out_last_reg <= pend_last_reg;
            end else if (in_take) begin
                out_byte_reg <= in_byte_reg;
                out_crc_reg  <= 1'b0;
                out_last_reg <= 1'b0;
            end
        end
        if (in_take && close_block) begin
            pend_crc_reg  <= ~crc_upd;
            pend_last_reg <= in_eom_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign is_crc    = out_crc_reg;
    assign last_out  = out_last_reg;

endmodule

### rtl/bci_checker.sv
module bci_checker
    import bci_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] data_byte,
    input logic       end_of_message,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       is_crc,
    input logic       last_out
);

    // A stalled output octet keeps its value and its marks.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(is_crc) && $stable(last_out))
        else $error("output item changed while stalled");

    // A waiting input item is held by the sender until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(data_byte)
            && $stable(end_of_message))
        else $error("input item changed while waiting");

    // Only a CRC octet can close a message.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_out |-> is_crc)
        else $error("message end marked on a data octet");

    // The input side stalls only while the output holds an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with an empty output");

    // Reset leaves no output item behind.
    assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid right after reset");

endmodule

bind block_crc16_inserter_top bci_checker u_bci_checker (.*);
